FILE: src/itc_pkg.sv
// ----------------------------------------------------------------------------
// itc_pkg: shared types and constants for the integer to text converter
// Holds the number kind codes, controller states, the command and status
// bundles between controller and datapath, and the digit to ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package itc_pkg;

  // widths of the number and of the packed decimal register
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned HALF_W     = VAL_W / 2;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIG_W      = NUM_DIGITS * 4;
  localparam int unsigned ITER_W     = 7;
  localparam int unsigned REM_W      = 5;
  localparam int unsigned CHAR_W     = 7;

  // number kind codes carried on the input side
  localparam logic [1:0] KIND_S32 = 2'd0;
  localparam logic [1:0] KIND_U32 = 2'd1;
  localparam logic [1:0] KIND_S64 = 2'd2;
  localparam logic [1:0] KIND_U64 = 2'd3;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_TRIM,
    ST_SIGN,
    ST_EMIT
  } itc_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture a new number
    logic dabble;      // one shift and add-3 step
    logic shift;       // drop the top digit
    logic emit_sign;   // load the minus sign into the output register
    logic emit_digit;  // load the top digit into the output register
  } itc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic iter_zero;   // conversion steps all done
    logic top_zero;    // top digit is zero
    logic rem_one;     // one digit left
    logic neg;         // number prints with a minus sign
  } itc_sts_t;

  // one digit value to its lower-case ascii code
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_LOWER_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage : itc_pkg

`default_nettype wire

FILE: src/itc_dp.sv
// ----------------------------------------------------------------------------
// itc_dp: datapath of the integer to text converter
// Sign handling, serial binary to packed decimal conversion, digit register
// with leading zero removal, and the output word register payload.
// ----------------------------------------------------------------------------
`default_nettype none

module itc_dp
  import itc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [VAL_W-1:0]  value,
  input  wire logic [1:0]        number_kind,
  input  wire logic              hex_mode,
  input  wire itc_cmd_t          cmd,
  output itc_sts_t               sts,
  output logic [CHAR_W-1:0]      character,
  output logic                   last_char
);

  localparam logic [ITER_W-1:0] ITER_WIDE   = ITER_W'(VAL_W);
  localparam logic [ITER_W-1:0] ITER_NARROW = ITER_W'(HALF_W);
  localparam logic [REM_W-1:0]  REM_FULL    = REM_W'(NUM_DIGITS);

  logic [VAL_W-1:0]  mag_r, mag_nxt;
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              neg_r, neg_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;

  logic              wide;
  logic              is_signed;
  logic              negative;
  logic [VAL_W-1:0]  masked;
  logic [VAL_W-1:0]  magnitude;
  logic [HALF_W-1:0] mag_narrow;
  logic [DIG_W-1:0]  adj;

  // kind decode and unsigned magnitude of the incoming number
  always_comb begin
    wide       = (number_kind == KIND_S64) || (number_kind == KIND_U64);
    is_signed  = (number_kind == KIND_S32) || (number_kind == KIND_S64);
    masked     = wide ? value : {{HALF_W{1'b0}}, value[HALF_W-1:0]};
    negative   = !hex_mode && is_signed &&
                 (wide ? value[VAL_W-1] : value[HALF_W-1]);
    mag_narrow = negative ? (~value[HALF_W-1:0] + 1'b1) : value[HALF_W-1:0];
    if (wide) begin
      magnitude = negative ? (~value + 1'b1) : value;
    end else begin
      // narrow numbers sit in the top half so fewer steps are needed
      magnitude = {mag_narrow, {HALF_W{1'b0}}};
    end
  end

  // add 3 to every decimal digit of five or more
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3
                                                : dig_r[4*i +: 4];
    end
  end

  // next values of the datapath registers
  always_comb begin
    mag_nxt  = mag_r;
    dig_nxt  = dig_r;
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (cmd.load) begin
      neg_nxt = negative;
      rem_nxt = REM_FULL;
      mag_nxt = magnitude;
      if (hex_mode) begin
        dig_nxt  = {{(DIG_W-VAL_W){1'b0}}, masked};
        iter_nxt = '0;
      end else begin
        dig_nxt  = '0;
        iter_nxt = wide ? ITER_WIDE : ITER_NARROW;
      end
    end
    if (cmd.dabble) begin
      dig_nxt  = {adj[DIG_W-2:0], mag_r[VAL_W-1]};
      mag_nxt  = {mag_r[VAL_W-2:0], 1'b0};
      iter_nxt = iter_r - 1'b1;
    end
    if (cmd.emit_sign) begin
      char_nxt = CHAR_MINUS;
      last_nxt = 1'b0;
    end
    if (cmd.emit_digit) begin
      char_nxt = digit_char(dig_r[DIG_W-1 -: 4]);
      last_nxt = (rem_r == 5'd1);
    end
    if (cmd.shift) begin
      dig_nxt = {dig_r[DIG_W-5:0], 4'h0};
      rem_nxt = rem_r - 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    dig_r  <= dig_nxt;
    iter_r <= iter_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  // status back to the controller
  always_comb begin
    sts.iter_zero = (iter_r == '0);
    sts.top_zero  = (dig_r[DIG_W-1 -: 4] == 4'h0);
    sts.rem_one   = (rem_r == 5'd1);
    sts.neg       = neg_r;
  end

  assign character = char_r;
  assign last_char = last_r;

endmodule : itc_dp

`default_nettype wire

FILE: src/itc_ctrl.sv
// ----------------------------------------------------------------------------
// itc_ctrl: controller of the integer to text converter
// Sequences load, conversion, leading zero removal and emission of the
// characters, and owns the valid flag of the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module itc_ctrl
  import itc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire itc_sts_t sts,
  output itc_cmd_t      cmd
);

  itc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (sts.iter_zero) begin
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (!sts.top_zero || sts.rem_one) begin
          state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && sts.rem_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_CONVERT: begin
        cmd.dabble = !sts.iter_zero;
      end
      ST_TRIM: begin
        cmd.shift = sts.top_zero && !sts.rem_one;
      end
      ST_SIGN: begin
        cmd.emit_sign = out_free;
      end
      ST_EMIT: begin
        cmd.emit_digit = out_free;
        cmd.shift      = out_free;
      end
      default: cmd = '0;
    endcase
    if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // a word is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> out_free)
    else $error("character loaded over a word still waiting");

  // the minus sign is only sent for negative decimal numbers
  a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN) |-> sts.neg)
    else $error("sign state entered for a non-negative number");

  // commands that move the digit register never coincide with a load
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.dabble, cmd.shift}))
    else $error("conflicting datapath commands");

  // after the final digit the block is ready for the next word
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && sts.rem_one) |=> (state_r == ST_IDLE))
    else $error("block not idle after final character");

endmodule : itc_ctrl

`default_nettype wire

FILE: src/integer_to_text_converter.sv
// Sequence: a decimal word runs 32 (32-bit kinds) or 64 (64-bit kinds) serial
//   shift and add-3 steps, a hex word none; leading zero digits are then trimmed
//   from the 20-digit register (up to 19), a minus sign goes out if negative,
//   then one digit a cycle while the output register is free. A new input word
//   is accepted only once the final character of the previous one is loaded.
//   Reset: rst_n idles it.
// ----------------------------------------------------------------------------
// integer_to_text_converter: integer to ascii text, one character per word
// Converts a 32 or 64 bit signed or unsigned integer to decimal or lower-case
// hex text, most significant character first, marking the final character.
// Synchronous active-low reset empties the output register; payload registers
// are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_text_converter
  import itc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input stream
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [VAL_W-1:0] in_tdata,   // [63:0] value
  input  wire logic [2:0]       in_tuser,   // [1:0] number_kind, [2] hex_mode
  // result stream
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,  // [6:0] character, [7] zero
  output logic                  out_tlast   // last_char
);

  itc_cmd_t          cmd;
  itc_sts_t          sts;
  logic [CHAR_W-1:0] character;

  // sequencing
  itc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // conversion and character datapath
  itc_dp u_dp (
    .clk         (clk),
    .value       (in_tdata),
    .number_kind (in_tuser[1:0]),
    .hex_mode    (in_tuser[2]),
    .cmd         (cmd),
    .sts         (sts),
    .character   (character),
    .last_char   (out_tlast)
  );

  assign out_tdata = {1'b0, character};

endmodule : integer_to_text_converter

`default_nettype wire
